>>> rtl/gn3d_pkg.sv
`default_nettype none
package gn3d_pkg;

  localparam int LATTICE_SIZE = 256;
  localparam int IDX_W        = $clog2(LATTICE_SIZE);
  localparam int FRAC_W       = 16;
  localparam int COORD_W      = 29;
  localparam int GRAD_W       = 16;
  localparam int PROD_W       = 19;   // r*g after dropping 14 fraction bits
  localparam int DOT_W        = 21;
  localparam int LV_W         = 22;   // lerp operand width
  localparam int NOISE_W      = 18;

  localparam logic [1:0] OP_EVAL = 2'd0;
  localparam logic [1:0] OP_PERM = 2'd1;
  localparam logic [1:0] OP_GRAD = 2'd2;

  localparam logic REG_PERIOD_MASK = 1'b0;
  localparam logic [7:0] PERIOD_MASK_RST = 8'hff;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [FRAC_W-1:0] frac_t;

  typedef struct packed {
    logic [GRAD_W-1:0] z;
    logic [GRAD_W-1:0] y;
    logic [GRAD_W-1:0] x;
  } grad_t;

  // corner n: bit 0 selects x far, bit 1 y far, bit 2 z far
  typedef struct packed {
    logic            valid;
    grad_t [7:0]     g;
    frac_t           rx;
    frac_t           ry;
    frac_t           rz;
    frac_t           sx;
    frac_t           sy;
    frac_t           sz;
  } lk_t;

endpackage
`default_nettype wire

>>> rtl/gn3d_fade.sv
`default_nettype none
module gn3d_fade
  import gn3d_pkg::*;
(
  input  wire logic  clk,
  input  wire frac_t t,
  output frac_t      s
);

  frac_t       t2;
  logic [17:0] k;
  logic [31:0] sq;
  logic [33:0] pr;

  always_comb begin
    sq = t * t;
    pr = t2 * k;
  end

  always_ff @(posedge clk) begin
    t2 <= sq[31:16];
    k  <= 18'd196608 - {1'b0, t, 1'b0};
    s  <= pr[31:16];
  end

endmodule
`default_nettype wire

>>> rtl/gn3d_lookup.sv
`default_nettype none
module gn3d_lookup
  import gn3d_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      take,
  input  wire logic [1:0]                op,
  input  wire logic signed [COORD_W-1:0] coord_x,
  input  wire logic signed [COORD_W-1:0] coord_y,
  input  wire logic signed [COORD_W-1:0] coord_z,
  input  wire logic [7:0]                table_index,
  input  wire logic [7:0]                perm_value,
  input  wire logic signed [GRAD_W-1:0]  grad_x,
  input  wire logic signed [GRAD_W-1:0]  grad_y,
  input  wire logic signed [GRAD_W-1:0]  grad_z,
  input  wire logic [7:0]                period_mask,
  output lk_t                            lk
);

  // permutation copies: a for the x lookup, b0/b1 for the y lookups
  logic [7:0] perm_a  [LATTICE_SIZE];
  logic [7:0] perm_b0 [LATTICE_SIZE];
  logic [7:0] perm_b1 [LATTICE_SIZE];
  grad_t      grad_m  [4][LATTICE_SIZE];

  // stage 1
  logic       v1;
  logic [1:0] op1;
  idx_t       bx0, bx1, by0_1, by1_1, bz0_1, bz1_1, widx1;
  frac_t      rx1, ry1, rz1;
  logic [7:0] pval1;
  grad_t      gval1;
  // stage 2
  logic       v2;
  logic [1:0] op2;
  idx_t       i2, j2, by0_2, by1_2, bz0_2, bz1_2, widx2;
  frac_t      rx2, ry2, rz2;
  grad_t      gval2;
  logic [7:0] pval2_q;
  // stage 3
  logic       v3;
  logic [1:0] op3;
  idx_t       b00, b10, b01, b11, bz0_3, bz1_3, widx3;
  frac_t      rx3, ry3, rz3;
  grad_t      gval3;
  idx_t       b3 [4];
  // stage 4, gathered into lk
  logic       lk_valid;
  grad_t      lk_g [8];
  frac_t      lk_rx, lk_ry, lk_rz, lk_sx, lk_sy, lk_sz;

  frac_t      fx, fy, fz;
  logic [7:0] ix, iy, iz;

  always_comb begin
    ix = coord_x[23:16] & period_mask;
    iy = coord_y[23:16] & period_mask;
    iz = coord_z[23:16] & period_mask;
    b3[0] = b00;
    b3[1] = b10;
    b3[2] = b01;
    b3[3] = b11;
  end

  always_comb begin
    lk.valid = lk_valid;
    for (int n = 0; n < 8; n++) begin
      lk.g[n] = lk_g[n];
    end
    lk.rx = lk_rx;
    lk.ry = lk_ry;
    lk.rz = lk_rz;
    lk.sx = lk_sx;
    lk.sy = lk_sy;
    lk.sz = lk_sz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      lk_valid <= 1'b0;
    end else begin
      v1 <= take && (op == OP_EVAL || op == OP_PERM || op == OP_GRAD);
      v2 <= v1;
      v3 <= v2;
      lk_valid <= v3 && (op3 == OP_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    op1   <= op;
    bx0   <= IDX_W'(ix);
    bx1   <= IDX_W'((ix + 8'd1) & period_mask);
    by0_1 <= IDX_W'(iy);
    by1_1 <= IDX_W'((iy + 8'd1) & period_mask);
    bz0_1 <= IDX_W'(iz);
    bz1_1 <= IDX_W'((iz + 8'd1) & period_mask);
    rx1   <= coord_x[15:0];
    ry1   <= coord_y[15:0];
    rz1   <= coord_z[15:0];
    widx1 <= IDX_W'(table_index);
    pval1 <= perm_value;
    gval1 <= '{z: grad_z, y: grad_y, x: grad_x};

    op2     <= op1;
    by0_2   <= by0_1;
    by1_2   <= by1_1;
    bz0_2   <= bz0_1;
    bz1_2   <= bz1_1;
    rx2     <= rx1;
    ry2     <= ry1;
    rz2     <= rz1;
    widx2   <= widx1;
    gval2   <= gval1;
    pval2_q <= pval1;

    op3   <= op2;
    bz0_3 <= bz0_2;
    bz1_3 <= bz1_2;
    rx3   <= rx2;
    ry3   <= ry2;
    rz3   <= rz2;
    widx3 <= widx2;
    gval3 <= gval2;

    lk_rx <= rx3;
    lk_ry <= ry3;
    lk_rz <= rz3;
    lk_sx <= fx;
    lk_sy <= fy;
    lk_sz <= fz;
  end

  // each copy is written when the load request passes the stage that reads it,
  // so requests see the tables in arrival order
  always_ff @(posedge clk) begin
    if (v1 && op1 == OP_PERM) begin
      perm_a[widx1] <= pval1;
    end
    i2 <= perm_a[bx0];
    j2 <= perm_a[bx1];
  end

  always_ff @(posedge clk) begin
    if (v2 && op2 == OP_PERM) begin
      perm_b0[widx2] <= pval2_q;
      perm_b1[widx2] <= pval2_q;
    end
    b00 <= perm_b0[IDX_W'(i2 + by0_2)];
    b10 <= perm_b0[IDX_W'(j2 + by0_2)];
    b01 <= perm_b1[IDX_W'(i2 + by1_2)];
    b11 <= perm_b1[IDX_W'(j2 + by1_2)];
  end

  for (genvar c = 0; c < 4; c++) begin : g_grad
    always_ff @(posedge clk) begin
      if (v3 && op3 == OP_GRAD) begin
        grad_m[c][widx3] <= gval3;
      end
      lk_g[c]     <= grad_m[c][IDX_W'(b3[c] + bz0_3)];
      lk_g[c + 4] <= grad_m[c][IDX_W'(b3[c] + bz1_3)];
    end
  end

  gn3d_fade u_fade_x (.clk(clk), .t(rx1), .s(fx));
  gn3d_fade u_fade_y (.clk(clk), .t(ry1), .s(fy));
  gn3d_fade u_fade_z (.clk(clk), .t(rz1), .s(fz));

endmodule
`default_nettype wire

>>> rtl/gn3d_lerp.sv
`default_nettype none
module gn3d_lerp
  import gn3d_pkg::*;
(
  input  wire logic                   clk,
  input  wire frac_t                  s,
  input  wire logic signed [LV_W-1:0] a,
  input  wire logic signed [LV_W-1:0] b,
  output logic signed [LV_W-1:0]      y
);

  logic signed [LV_W:0]      d;
  logic signed [LV_W+17:0]   pr;
  logic signed [LV_W+1:0]    pr_q;
  logic signed [LV_W-1:0]    a_q;

  always_comb begin
    d  = (LV_W+1)'(b) - (LV_W+1)'(a);
    pr = $signed({1'b0, s}) * d;
  end

  always_ff @(posedge clk) begin
    pr_q <= pr[LV_W+17:16];   // floor divide by 2^16
    a_q  <= a;
    y    <= a_q + LV_W'(pr_q);
  end

endmodule
`default_nettype wire

>>> rtl/gn3d_blend.sv
`default_nettype none
module gn3d_blend
  import gn3d_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lk_t                   lk,
  output logic                       done,
  output logic signed [NOISE_W-1:0]  noise_value
);

  logic signed [16:0]         rsel [3][2];
  logic signed [32:0]         prod [8][3];
  logic signed [PROD_W-1:0]   p    [8][3];
  logic signed [DOT_W-1:0]    dot  [8];
  logic signed [LV_W-1:0]     l1   [4];
  logic signed [LV_W-1:0]     l2   [2];
  logic signed [LV_W-1:0]     l3;
  logic [7:0]                 vp;
  frac_t                      sx_d [2];
  frac_t                      sy_d [4];
  frac_t                      sz_d [6];

  always_comb begin
    // far offset r - 1.0 is the fraction with a sign bit of one
    rsel[0][0] = $signed({1'b0, lk.rx});
    rsel[0][1] = $signed({1'b1, lk.rx});
    rsel[1][0] = $signed({1'b0, lk.ry});
    rsel[1][1] = $signed({1'b1, lk.ry});
    rsel[2][0] = $signed({1'b0, lk.rz});
    rsel[2][1] = $signed({1'b1, lk.rz});
    for (int n = 0; n < 8; n++) begin
      prod[n][0] = rsel[0][n % 2]       * $signed(lk.g[n].x);
      prod[n][1] = rsel[1][(n / 2) % 2] * $signed(lk.g[n].y);
      prod[n][2] = rsel[2][n / 4]       * $signed(lk.g[n].z);
    end
  end

  always_ff @(posedge clk) begin
    for (int n = 0; n < 8; n++) begin
      for (int k = 0; k < 3; k++) begin
        p[n][k] <= prod[n][k][32:14];
      end
      dot[n] <= DOT_W'(p[n][0]) + DOT_W'(p[n][1]) + DOT_W'(p[n][2]);
    end
    sx_d[0] <= lk.sx;
    sx_d[1] <= sx_d[0];
    sy_d[0] <= lk.sy;
    sz_d[0] <= lk.sz;
    for (int k = 1; k < 4; k++) sy_d[k] <= sy_d[k-1];
    for (int k = 1; k < 6; k++) sz_d[k] <= sz_d[k-1];
  end

  for (genvar m = 0; m < 4; m++) begin : g_lx
    gn3d_lerp u_lerp (
      .clk (clk),
      .s   (sx_d[1]),
      .a   (LV_W'(dot[2*m])),
      .b   (LV_W'(dot[2*m+1])),
      .y   (l1[m])
    );
  end

  for (genvar m = 0; m < 2; m++) begin : g_ly
    gn3d_lerp u_lerp (
      .clk (clk),
      .s   (sy_d[3]),
      .a   (l1[2*m]),
      .b   (l1[2*m+1]),
      .y   (l2[m])
    );
  end

  gn3d_lerp u_lerp_z (
    .clk (clk),
    .s   (sz_d[5]),
    .a   (l2[0]),
    .b   (l2[1]),
    .y   (l3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vp   <= '0;
      done <= 1'b0;
    end else begin
      vp   <= {vp[6:0], lk.valid};
      done <= vp[7];
    end
  end

  always_ff @(posedge clk) begin
    if (l3 > LV_W'(131071)) begin
      noise_value <= NOISE_W'(131071);
    end else if (l3 < -LV_W'(131072)) begin
      noise_value <= NOISE_W'(-131072);
    end else begin
      noise_value <= l3[NOISE_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/gradient_noise_3d.sv
`default_nettype none
// 3D gradient noise, one request per clock.
// Requests: start is taken whenever busy is low; busy never rises, so a
// request may be issued in every cycle. op selects evaluate, load of a
// permutation entry, or load of a gradient entry; op 3 is dropped.
// Loads produce no result. Tables must be loaded before they are read.
// Results: an evaluate yields noise_value with done high for one cycle,
// in request order. The receiver cannot stall, so the pipeline never holds.
// Throughput is one request per cycle: the table lookups use replicated
// copies of both tables (two read ports each), the dot products use 24
// multipliers, and the seven lerps are two-stage units in a tree.
// Config: APB register 0 (byte 0) is period_mask, to be written only while
// idle; the block does not enforce this. Reset clears the pipeline valid
// bits and sets period_mask to 0xff; table contents are not cleared.
module gradient_noise_3d
  import gn3d_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                op,
  input  wire logic signed [COORD_W-1:0] coord_x,
  input  wire logic signed [COORD_W-1:0] coord_y,
  input  wire logic signed [COORD_W-1:0] coord_z,
  input  wire logic [7:0]                table_index,
  input  wire logic [7:0]                perm_value,
  input  wire logic signed [GRAD_W-1:0]  grad_x,
  input  wire logic signed [GRAD_W-1:0]  grad_y,
  input  wire logic signed [GRAD_W-1:0]  grad_z,
  output logic                           done,
  output logic signed [NOISE_W-1:0]      noise_value,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [7:0] period_mask;
  lk_t        lk;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_mask <= PERIOD_MASK_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PERIOD_MASK) begin
      period_mask <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PERIOD_MASK) begin
      prdata = {24'd0, period_mask};
    end
  end

  gn3d_lookup u_lookup (
    .clk         (clk),
    .rst         (rst),
    .take        (start && !busy),
    .op          (op),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .table_index (table_index),
    .perm_value  (perm_value),
    .grad_x      (grad_x),
    .grad_y      (grad_y),
    .grad_z      (grad_z),
    .period_mask (period_mask),
    .lk          (lk)
  );

  gn3d_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .lk          (lk),
    .done        (done),
    .noise_value (noise_value)
  );

endmodule
`default_nettype wire

>>> tb/gradient_noise_3d_test.sv
`timescale 1ns / 100ps
module gradient_noise_3d_test;
  import gn3d_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [1:0]  op;
    logic [28:0] x, y, z;
    logic [7:0]  idx, pv;
    logic [15:0] gx, gy, gz;
  } req_t;

  class noise_scoreboard;
    logic [7:0]  perm[LATTICE_SIZE];
    logic [47:0] grad[LATTICE_SIZE];
    logic [7:0]  mask;
    logic [17:0] noise_q[$];
    int errors, evals, loads;

    function new();
      mask = PERIOD_MASK_RST;
    endfunction

    function longint fade(longint t);
      longint t2;
      t2 = (t * t) >>> 16;
      return (t2 * (196608 - 2 * t)) >>> 16;
    endfunction

    function longint lerp(longint s, longint a, longint b);
      return a + ((s * (b - a)) >>> 16);
    endfunction

    function longint dot(int idx, longint rx, longint ry, longint rz);
      logic [47:0] g;
      g = grad[idx % LATTICE_SIZE];
      return ((rx * longint'($signed(g[15:0]))) >>> 14)
           + ((ry * longint'($signed(g[31:16]))) >>> 14)
           + ((rz * longint'($signed(g[47:32]))) >>> 14);
    endfunction

    function void note(req_t r);
      int b0[3], b1[3], i, j, c00, c10, c01, c11;
      longint r0[3], r1[3], t, sy, sz, a, bb, c, d, res;
      logic [28:0] raw[3];
      case (r.op)
        OP_PERM: begin
          perm[r.idx] = r.pv;
          loads++;
        end
        OP_GRAD: begin
          grad[r.idx] = {r.gz, r.gy, r.gx};
          loads++;
        end
        OP_EVAL: begin
          raw[0] = r.x; raw[1] = r.y; raw[2] = r.z;
          for (int k = 0; k < 3; k++) begin
            b0[k] = int'(raw[k][23:16] & mask);
            b1[k] = (b0[k] + 1) & int'(mask);
            r0[k] = longint'(raw[k][15:0]);
            r1[k] = r0[k] - 65536;
          end
          i = int'(perm[b0[0]]);
          j = int'(perm[b1[0]]);
          c00 = int'(perm[(i + b0[1]) % LATTICE_SIZE]);
          c10 = int'(perm[(j + b0[1]) % LATTICE_SIZE]);
          c01 = int'(perm[(i + b1[1]) % LATTICE_SIZE]);
          c11 = int'(perm[(j + b1[1]) % LATTICE_SIZE]);
          t = fade(r0[0]); sy = fade(r0[1]); sz = fade(r0[2]);
          a  = lerp(t, dot(c00 + b0[2], r0[0], r0[1], r0[2]),
                       dot(c10 + b0[2], r1[0], r0[1], r0[2]));
          bb = lerp(t, dot(c01 + b0[2], r0[0], r1[1], r0[2]),
                       dot(c11 + b0[2], r1[0], r1[1], r0[2]));
          c = lerp(sy, a, bb);
          a  = lerp(t, dot(c00 + b1[2], r0[0], r0[1], r1[2]),
                       dot(c10 + b1[2], r1[0], r0[1], r1[2]));
          bb = lerp(t, dot(c01 + b1[2], r0[0], r1[1], r1[2]),
                       dot(c11 + b1[2], r1[0], r1[1], r1[2]));
          d = lerp(sy, a, bb);
          res = lerp(sz, c, d);
          if (res > 131071) res = 131071;
          if (res < -131072) res = -131072;
          noise_q.push_back(res[17:0]);
          evals++;
        end
        default: ;
      endcase
    endfunction

    function void check(logic [17:0] got);
      logic [17:0] want;
      if (noise_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result noise_value=%0d", $signed(got));
        return;
      end
      want = noise_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("noise_value mismatch: expected %0d got %0d",
                   $signed(want), $signed(got));
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done, psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic signed [NOISE_W-1:0] noise_value;
  req_t cur;
  bit idle_on;
  int cycles = 0;
  noise_scoreboard sb;

  gradient_noise_3d dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(cur.op),
    .coord_x(cur.x), .coord_y(cur.y), .coord_z(cur.z),
    .table_index(cur.idx), .perm_value(cur.pv),
    .grad_x(cur.gx), .grad_y(cur.gy), .grad_z(cur.gz),
    .done(done), .noise_value(noise_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst) begin
      if (start && !busy) sb.note(cur);
      if (done) sb.check(noise_value);
    end
  end

  task send(input req_t r);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      @(negedge clk);
    end
    cur <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off requests until every evaluate has returned, then let the pipe drain
  task wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.noise_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_mask(input logic [7:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_PERIOD_MASK, 2'b00}; pwdata <= {24'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.mask = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function req_t mk(logic [1:0] op);
    req_t r;
    r.op = op;
    r.x = 29'($urandom); r.y = 29'($urandom); r.z = 29'($urandom);
    r.idx = 8'($urandom); r.pv = 8'($urandom);
    r.gx = 16'($urandom_range(0, 32768) - 16384);
    r.gy = 16'($urandom_range(0, 32768) - 16384);
    r.gz = 16'($urandom_range(0, 32768) - 16384);
    return r;
  endfunction

  function req_t rand_req();
    req_t r;
    int p;
    p = $urandom_range(0, 99);
    r = mk(p < 85 ? OP_EVAL : p < 91 ? OP_PERM : p < 97 ? OP_GRAD : OP_NONE);
    // some gradients beyond +/-1.0 in Q1.14, full 16-bit range
    if ($urandom_range(0, 9) == 0) begin
      r.gx = 16'($urandom); r.gy = 16'($urandom); r.gz = 16'($urandom);
    end
    // small coordinates now and then, around the origin
    if ($urandom_range(0, 3) == 0) begin
      r.x = $signed(29'($urandom_range(0, 'h80000))) - 29'h40000;
      r.y = $signed(29'($urandom_range(0, 'h80000))) - 29'h40000;
      r.z = $signed(29'($urandom_range(0, 'h80000))) - 29'h40000;
    end
    return r;
  endfunction

  logic [7:0] masks[6] = '{8'hff, 8'h00, 8'h0f, 8'h01, 8'h7f, 8'hff};
  logic [28:0] edges[5] = '{29'h0fffffff, 29'h10000000, 29'h0, 29'h0000ffff, 29'h1fffffff};
  logic [15:0] gedges[5] = '{16'h4000, 16'hc000, 16'h7fff, 16'h8000, 16'h0000};

  initial begin
    req_t r;
    sb = new();
    rst = 1'b1; start = 1'b0; idle_on = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cur = mk(OP_NONE);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every table entry gets written before any evaluate
    for (int n = 0; n < LATTICE_SIZE; n++) begin
      r = mk(OP_PERM); r.idx = n; send(r);
      r = mk(OP_GRAD); r.idx = n; send(r);
    end

    // directed: field extremes, out-of-range gradients, dropped op
    for (int n = 0; n < 5; n++) begin
      r = mk(OP_GRAD); r.gx = gedges[n]; r.gy = gedges[(n + 1) % 5];
      r.gz = gedges[(n + 2) % 5]; send(r);
    end
    for (int n = 0; n < 5; n++) begin
      r = mk(OP_EVAL); r.x = edges[n]; r.y = edges[(n + 2) % 5];
      r.z = edges[(n + 4) % 5]; send(r);
    end
    r = mk(OP_NONE); send(r);
    r = mk(OP_PERM); r.idx = 8'hff; r.pv = 8'hff; send(r);
    r = mk(OP_PERM); r.idx = 8'h00; r.pv = 8'h00; send(r);
    r = mk(OP_EVAL); r.x = 29'h00ff8000; r.y = 29'h0; r.z = 29'h1fff0001; send(r);
    r = mk(OP_EVAL); send(r);

    foreach (masks[p]) begin
      wait_idle();
      write_mask(masks[p]);
      idle_on = (p != 2);
      for (int n = 0; n < 200; n++) send(rand_req());
    end

    wait_idle();
    if (sb.noise_q.size() != 0) sb.errors++;
    $display("%0d evaluates, %0d table loads, %0d period_mask settings incl. 0x00 and 0xff",
             sb.evals, sb.loads, $size(masks));
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
